>>> rtl/four_wheel_position_pid_macros.svh
// Assertion macros for the four-wheel position PID block.
// Taken in by the top level; no other dependencies.
`ifndef FOUR_WHEEL_POSITION_PID_MACROS_SVH
`define FOUR_WHEEL_POSITION_PID_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define FWPP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define FWPP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fwpp_pkg.sv
// Shared types, constants and saturation helpers for the four-wheel position PID.
// No dependencies; used by every module of the block.
package fwpp_pkg;

  localparam int WHEELS   = 4;
  localparam int WHEEL_W  = 2;
  localparam int POS_W    = 24;
  localparam int ACC_W    = 32;
  localparam int VEL_W    = 11;
  localparam int GAIN_W   = 32;
  localparam int ZONE_W   = 16;
  localparam int BAND_W   = 8;
  localparam int DRIVE_W  = 8;
  localparam int FRAC_W   = 16;
  localparam int PROD_P_W = GAIN_W + POS_W;
  localparam int PROD_I_W = GAIN_W + ACC_W;
  localparam int PROD_D_W = GAIN_W + VEL_W;
  localparam int SUM_W    = PROD_I_W + 1;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  localparam logic [2:0] REG_GAIN_P = 3'd0;
  localparam logic [2:0] REG_GAIN_I = 3'd1;
  localparam logic [2:0] REG_GAIN_D = 3'd2;
  localparam logic [2:0] REG_ZONE   = 3'd3;
  localparam logic [2:0] REG_BAND   = 3'd4;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 32'sd13107;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 32'sd52;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = -32'sd32768;
  localparam logic [ZONE_W-1:0]        ZONE_RST   = 16'd200;
  localparam logic [BAND_W-1:0]        BAND_RST   = 8'd5;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd127;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd127;

  typedef logic signed [POS_W-1:0]    pos_t;
  typedef logic signed [POS_W:0]      pos_ext_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic signed [ACC_W:0]      acc_ext_t;
  typedef logic signed [VEL_W-1:0]    vel_t;
  typedef logic signed [PROD_P_W-1:0] prod_p_t;
  typedef logic signed [PROD_I_W-1:0] prod_i_t;
  typedef logic signed [PROD_D_W-1:0] prod_d_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic               action;
    logic [WHEEL_W-1:0] wheel;
    pos_t               target;
    pos_t               position;
    vel_t               velocity;
  } fwpp_item_t;

  // Error, integral and status of one item after the wheel state update.
  typedef struct packed {
    logic tick;
    pos_t err;
    acc_t acc;
    vel_t vel;
    logic settled;
    logic all_settled;
  } fwpp_s1_t;

  typedef struct packed {
    logic                       all_settled;
    logic                       settled;
    logic signed [POS_W-1:0]    error;
    logic signed [DRIVE_W-1:0]  drive;
  } fwpp_res_t;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } fwpp_adv_t;

  function automatic pos_t sat_pos(input pos_ext_t v);
    pos_t r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic acc_t sat_acc(input acc_ext_t v);
    acc_t r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/four_wheel_position_pid.sv
// Four-wheel position PID: one item per cycle, four registered stages.
// An accepted item passes through them in order (input register, wheel state
// update, gain products, result register) before its result is valid.
// Throughput: one item per cycle; a stage holds while the next cannot take it.
// Reset (rst_n low, synchronous) empties the pipeline, loads the default gains,
// zone and band, clears all wheel state and marks every wheel settled.
`include "four_wheel_position_pid_macros.svh"

module four_wheel_position_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [23:0] target, [47:24] position, [58:48] velocity, [63:59] zero
  input  logic [fwpp_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] action, [2:1] wheel
  input  logic [fwpp_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] drive, [31:8] error, [32] settled, [33] all_settled, [39:34] zero
  output logic [fwpp_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fwpp_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [fwpp_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [fwpp_pkg::DATA_W-1:0]         cfg_prdata,
  output logic                                cfg_pready
);

  logic signed [fwpp_pkg::GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [fwpp_pkg::ZONE_W-1:0] zone_r;
  logic [fwpp_pkg::BAND_W-1:0] band_r;
  logic [2:0] cfg_idx;
  logic cfg_wr;

  logic v0_r, v1_r, v2_r, out_valid_r;
  logic rdy1, rdy2, rdy3;
  fwpp_pkg::fwpp_item_t item_r;
  fwpp_pkg::fwpp_adv_t adv;
  fwpp_pkg::fwpp_s1_t s1;
  fwpp_pkg::fwpp_res_t res, out_res_r;
  logic [fwpp_pkg::POS_W-1:0] out_err_mag;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[fwpp_pkg::ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= fwpp_pkg::GAIN_P_RST;
      gain_i_r <= fwpp_pkg::GAIN_I_RST;
      gain_d_r <= fwpp_pkg::GAIN_D_RST;
      zone_r   <= fwpp_pkg::ZONE_RST;
      band_r   <= fwpp_pkg::BAND_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fwpp_pkg::REG_GAIN_P: gain_p_r <= cfg_pwdata;
        fwpp_pkg::REG_GAIN_I: gain_i_r <= cfg_pwdata;
        fwpp_pkg::REG_GAIN_D: gain_d_r <= cfg_pwdata;
        fwpp_pkg::REG_ZONE:   zone_r   <= cfg_pwdata[fwpp_pkg::ZONE_W-1:0];
        fwpp_pkg::REG_BAND:   band_r   <= cfg_pwdata[fwpp_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fwpp_pkg::REG_GAIN_P: cfg_prdata = gain_p_r;
      fwpp_pkg::REG_GAIN_I: cfg_prdata = gain_i_r;
      fwpp_pkg::REG_GAIN_D: cfg_prdata = gain_d_r;
      fwpp_pkg::REG_ZONE:   cfg_prdata = fwpp_pkg::DATA_W'(zone_r);
      fwpp_pkg::REG_BAND:   cfg_prdata = fwpp_pkg::DATA_W'(band_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // A stage may load when it is empty or its contents move on this cycle.
  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  assign adv.s1_load = v0_r && rdy1;
  assign adv.s2_load = v1_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready)  v0_r        <= in_tvalid;
      if (rdy1)       v1_r        <= v0_r;
      if (rdy2)       v2_r        <= v1_r;
      if (rdy3)       out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action   <= in_tuser[0];
      item_r.wheel    <= in_tuser[2:1];
      item_r.target   <= in_tdata[23:0];
      item_r.position <= in_tdata[47:24];
      item_r.velocity <= in_tdata[58:48];
    end
  end

  fwpp_state u_state (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .item          (item_r),
    .integral_zone (zone_r),
    .settle_band   (band_r),
    .s1_r          (s1)
  );

  fwpp_drive u_drive (
    .clk    (clk),
    .adv    (adv),
    .s1     (s1),
    .gain_p (gain_p_r),
    .gain_i (gain_i_r),
    .gain_d (gain_d_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = fwpp_pkg::OUT_DATA_W'(out_res_r);

  assign out_err_mag = out_res_r.error[fwpp_pkg::POS_W-1] ? -out_res_r.error
                                                          : out_res_r.error;

  `FWPP_ASSERT_IMP(a_drive_range, clk, rst_n, out_valid_r,
    out_res_r.drive != -8'sd128, "drive outside -127..127")
  `FWPP_ASSERT_IMP(a_all_implies_own, clk, rst_n, out_valid_r && out_res_r.all_settled,
    out_res_r.settled, "all wheels settled but this wheel is not")
  `FWPP_ASSERT_IMP(a_settled_band, clk, rst_n, out_valid_r && out_res_r.settled,
    out_err_mag <= fwpp_pkg::POS_W'(band_r), "settled with error outside band")
  `FWPP_ASSERT_NXT(a_stage_to_out, clk, rst_n, v2_r && rdy3,
    out_valid_r, "product stage advanced but no result became valid")

endmodule

>>> rtl/fwpp_state.sv
// Per-wheel state (goal, offset, last corrected position, integral, settled flags)
// and the error and integral update of one item. Depends on fwpp_pkg.
module fwpp_state (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fwpp_pkg::fwpp_adv_t                adv,
  input  fwpp_pkg::fwpp_item_t               item,
  input  logic [fwpp_pkg::ZONE_W-1:0]        integral_zone,
  input  logic [fwpp_pkg::BAND_W-1:0]        settle_band,
  output fwpp_pkg::fwpp_s1_t                 s1_r
);

  fwpp_pkg::pos_t goal_r   [fwpp_pkg::WHEELS];
  fwpp_pkg::pos_t offset_r [fwpp_pkg::WHEELS];
  fwpp_pkg::pos_t lastc_r  [fwpp_pkg::WHEELS];
  fwpp_pkg::acc_t acc_r    [fwpp_pkg::WHEELS];
  logic [fwpp_pkg::WHEELS-1:0] flags_r;
  logic [fwpp_pkg::WHEELS-1:0] flags_nxt;

  fwpp_pkg::pos_t goal_cur, offset_cur, lastc_cur, off_start, corr, err;
  fwpp_pkg::acc_t acc_cur, acc_sat, acc_nxt;
  logic [fwpp_pkg::POS_W-1:0] err_mag;
  logic settled_nxt;
  logic is_tick;

  always_comb begin
    is_tick    = (item.action == fwpp_pkg::ACT_TICK);
    goal_cur   = goal_r[item.wheel];
    offset_cur = offset_r[item.wheel];
    lastc_cur  = lastc_r[item.wheel];
    acc_cur    = acc_r[item.wheel];

    // A new move folds the residual of the old one into the offset.
    off_start = fwpp_pkg::sat_pos(fwpp_pkg::pos_ext_t'(goal_cur)
                                  - fwpp_pkg::pos_ext_t'(lastc_cur));
    corr      = fwpp_pkg::sat_pos(fwpp_pkg::pos_ext_t'(item.position)
                                  + fwpp_pkg::pos_ext_t'(offset_cur));
    if (is_tick) begin
      err = fwpp_pkg::sat_pos(fwpp_pkg::pos_ext_t'(goal_cur) - fwpp_pkg::pos_ext_t'(corr));
    end else begin
      err = fwpp_pkg::sat_pos(fwpp_pkg::pos_ext_t'(item.target)
                              - fwpp_pkg::pos_ext_t'(off_start));
    end
    err_mag = err[fwpp_pkg::POS_W-1] ? -err : err;

    acc_sat = fwpp_pkg::sat_acc(fwpp_pkg::acc_ext_t'(acc_cur) + fwpp_pkg::acc_ext_t'(err));
    if ((err == '0) || (err_mag > fwpp_pkg::POS_W'(integral_zone))) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_sat;
    end

    settled_nxt = (err_mag <= fwpp_pkg::POS_W'(settle_band));
    flags_nxt = flags_r;
    flags_nxt[item.wheel] = settled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '1;
      for (int k = 0; k < fwpp_pkg::WHEELS; k++) begin
        goal_r[k]   <= '0;
        offset_r[k] <= '0;
        lastc_r[k]  <= '0;
        acc_r[k]    <= '0;
      end
    end else if (adv.s1_load) begin
      flags_r <= flags_nxt;
      if (is_tick) begin
        lastc_r[item.wheel] <= corr;
        acc_r[item.wheel]   <= acc_nxt;
      end else begin
        offset_r[item.wheel] <= off_start;
        goal_r[item.wheel]   <= item.target;
        lastc_r[item.wheel]  <= off_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1_load) begin
      s1_r.tick        <= is_tick;
      s1_r.err         <= err;
      s1_r.acc         <= is_tick ? acc_nxt : acc_cur;
      s1_r.vel         <= item.velocity;
      s1_r.settled     <= settled_nxt;
      s1_r.all_settled <= &flags_nxt;
    end
  end

endmodule

>>> rtl/fwpp_drive.sv
// Gain products and the saturated drive command of one item.
// Depends on fwpp_pkg; fed by fwpp_state.
module fwpp_drive (
  input  logic                                  clk,
  input  fwpp_pkg::fwpp_adv_t                   adv,
  input  fwpp_pkg::fwpp_s1_t                    s1,
  input  logic signed [fwpp_pkg::GAIN_W-1:0]    gain_p,
  input  logic signed [fwpp_pkg::GAIN_W-1:0]    gain_i,
  input  logic signed [fwpp_pkg::GAIN_W-1:0]    gain_d,
  output fwpp_pkg::fwpp_res_t                   res
);

  fwpp_pkg::prod_p_t p_nxt, p_r;
  fwpp_pkg::prod_i_t i_nxt, i_r;
  fwpp_pkg::prod_d_t d_nxt, d_r;
  fwpp_pkg::fwpp_s1_t s2_r;
  fwpp_pkg::sum_t sum;
  fwpp_pkg::sum_t lim;
  logic signed [fwpp_pkg::DRIVE_W-1:0] quot;

  assign p_nxt = gain_p * $signed(s1.err);
  assign i_nxt = gain_i * $signed(s1.acc);
  assign d_nxt = gain_d * $signed(s1.vel);

  always_ff @(posedge clk) begin
    if (adv.s2_load) begin
      p_r  <= p_nxt;
      i_r  <= i_nxt;
      d_r  <= d_nxt;
      s2_r <= s1;
    end
  end

  // The three products cannot overflow the sum width, so no saturation is
  // needed before the drive clamp.
  always_comb begin
    sum  = fwpp_pkg::sum_t'(p_r) + fwpp_pkg::sum_t'(i_r) + fwpp_pkg::sum_t'(d_r);
    lim  = fwpp_pkg::sum_t'(fwpp_pkg::DRIVE_MAX) <<< fwpp_pkg::FRAC_W;
    quot = sum[fwpp_pkg::FRAC_W +: fwpp_pkg::DRIVE_W];
    // Division truncates toward zero: round a negative quotient up.
    if (sum[fwpp_pkg::SUM_W-1] && (sum[fwpp_pkg::FRAC_W-1:0] != '0)) begin
      quot = quot + 8'sd1;
    end
    res.all_settled = s2_r.all_settled;
    res.settled     = s2_r.settled;
    res.error       = s2_r.err;
    if (!s2_r.tick) begin
      res.drive = '0;
    end else if (sum >= lim) begin
      res.drive = fwpp_pkg::DRIVE_MAX;
    end else if (sum <= -lim) begin
      res.drive = fwpp_pkg::DRIVE_MIN;
    end else begin
      res.drive = quot;
    end
  end

endmodule

>>> tb/four_wheel_position_pid_test.sv
// Self-checking testbench for the four-wheel position PID block.
// Depends on fwpp_pkg and four_wheel_position_pid; it predicts every result in-line
// and compares it with the streamed output.
`timescale 1ns / 100ps

module four_wheel_position_pid_test;

  localparam logic [1:0] WHEEL_FR = 2'd0;
  localparam logic [1:0] WHEEL_FL = 2'd1;
  localparam logic [1:0] WHEEL_BR = 2'd2;
  localparam logic [1:0] WHEEL_BL = 2'd3;
  localparam fwpp_pkg::pos_t POS_HI = {1'b0, {(fwpp_pkg::POS_W-1){1'b1}}};
  localparam fwpp_pkg::pos_t POS_LO = {1'b1, {(fwpp_pkg::POS_W-1){1'b0}}};
  localparam int DRAIN_CYCLES = 8;
  localparam int WINDUP_TICKS = 100;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // [23:0] target, [47:24] position, [58:48] velocity, [63:59] zero
  logic [fwpp_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  // [0] action, [2:1] wheel
  logic [fwpp_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [7:0] drive, [31:8] error, [32] settled, [33] all_settled, [39:34] zero
  logic [fwpp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [fwpp_pkg::ADDR_W-1:0]     cfg_paddr = '0;
  logic [fwpp_pkg::DATA_W-1:0]     cfg_pwdata = '0;
  logic [fwpp_pkg::DATA_W-1:0]     cfg_prdata;
  logic                            cfg_pready;

  four_wheel_position_pid DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Mirror of the controller's tuning and per-wheel state.
  logic signed [fwpp_pkg::GAIN_W-1:0] tune_kp = fwpp_pkg::GAIN_P_RST;
  logic signed [fwpp_pkg::GAIN_W-1:0] tune_ki = fwpp_pkg::GAIN_I_RST;
  logic signed [fwpp_pkg::GAIN_W-1:0] tune_kd = fwpp_pkg::GAIN_D_RST;
  logic [fwpp_pkg::ZONE_W-1:0]        tune_zone = fwpp_pkg::ZONE_RST;
  logic [fwpp_pkg::BAND_W-1:0]        tune_band = fwpp_pkg::BAND_RST;
  fwpp_pkg::pos_t                     wheel_goal [fwpp_pkg::WHEELS];
  fwpp_pkg::pos_t                     wheel_offset [fwpp_pkg::WHEELS];
  fwpp_pkg::pos_t                     wheel_last [fwpp_pkg::WHEELS];
  fwpp_pkg::acc_t                     wheel_integral [fwpp_pkg::WHEELS];
  logic [fwpp_pkg::WHEELS-1:0]        wheel_settled = '1;

  fwpp_pkg::fwpp_res_t pending_drive_results [$];

  bit sender_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int ready_hold = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int starts_sent = 0;
  int ticks_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;

  initial begin
    for (int k = 0; k < fwpp_pkg::WHEELS; k++) begin
      wheel_goal[k] = '0;
      wheel_offset[k] = '0;
      wheel_last[k] = '0;
      wheel_integral[k] = '0;
    end
  end

  function automatic fwpp_pkg::pos_t clip_pos(input longint v);
    if (v > longint'(POS_HI)) return POS_HI;
    if (v < longint'(POS_LO)) return POS_LO;
    return fwpp_pkg::pos_t'(v);
  endfunction

  // Raw position that leaves the given wheel with the wanted error on its next tick.
  function automatic fwpp_pkg::pos_t aim_at(input logic [1:0] w, input longint miss);
    return clip_pos(longint'(wheel_goal[w]) - longint'(wheel_offset[w]) - miss);
  endfunction

  function automatic fwpp_pkg::fwpp_res_t predict_pid(input logic act, input logic [1:0] w,
                                                      input fwpp_pkg::pos_t tgt,
                                                      input fwpp_pkg::pos_t pos,
                                                      input fwpp_pkg::vel_t vel);
    fwpp_pkg::fwpp_res_t r;
    longint err;
    longint corr;
    longint acc;
    longint total;
    r = '0;
    if (act == fwpp_pkg::ACT_START) begin
      // The encoder restarts from zero, so the old residual moves into the offset.
      wheel_offset[w] = clip_pos(longint'(wheel_goal[w]) - longint'(wheel_last[w]));
      wheel_goal[w] = tgt;
      wheel_last[w] = wheel_offset[w];
      err = longint'(clip_pos(longint'(tgt) - longint'(wheel_offset[w])));
    end else begin
      corr = longint'(clip_pos(longint'(pos) + longint'(wheel_offset[w])));
      wheel_last[w] = fwpp_pkg::pos_t'(corr);
      err = longint'(clip_pos(longint'(wheel_goal[w]) - corr));
      if (err == 0 || (err < 0 ? -err : err) > longint'(tune_zone)) begin
        wheel_integral[w] = '0;
      end else begin
        acc = longint'(wheel_integral[w]) + err;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        wheel_integral[w] = fwpp_pkg::acc_t'(acc);
      end
      total = longint'(tune_kp) * err + longint'(tune_ki) * longint'(wheel_integral[w])
            + longint'(tune_kd) * longint'(vel);
      if (total > (64'sd128 <<< fwpp_pkg::FRAC_W)) total = 64'sd128 <<< fwpp_pkg::FRAC_W;
      if (total < -(64'sd128 <<< fwpp_pkg::FRAC_W)) total = -(64'sd128 <<< fwpp_pkg::FRAC_W);
      total = total / 65536;
      if (total > longint'(fwpp_pkg::DRIVE_MAX)) total = longint'(fwpp_pkg::DRIVE_MAX);
      if (total < longint'(fwpp_pkg::DRIVE_MIN)) total = longint'(fwpp_pkg::DRIVE_MIN);
      r.drive = total[fwpp_pkg::DRIVE_W-1:0];
    end
    wheel_settled[w] = ((err < 0 ? -err : err) <= longint'(tune_band));
    r.error = err[fwpp_pkg::POS_W-1:0];
    r.settled = wheel_settled[w];
    r.all_settled = &wheel_settled;
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic send_item(input logic act, input logic [1:0] w,
                           input fwpp_pkg::pos_t tgt, input fwpp_pkg::pos_t pos,
                           input fwpp_pkg::vel_t vel);
    fwpp_pkg::fwpp_res_t want;
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= {w, act};
    in_tdata <= {5'b0, vel, pos, tgt};
    do @(posedge clk); while (in_tready !== 1'b1);
    want = predict_pid(act, w, tgt, pos, vel);
    pending_drive_results.push_back(want);
    items_sent++;
    if (act == fwpp_pkg::ACT_START) starts_sent++;
    else ticks_sent++;
  endtask

  // Stops sending and waits until every expected transaction has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_drive_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic read_register(input logic [2:0] idx,
                               input logic [fwpp_pkg::DATA_W-1:0] want);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want)
      flag_mismatch($sformatf("register %0d read %h, expected %h", idx, cfg_prdata, want));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic write_register(input logic [2:0] idx,
                                input logic [fwpp_pkg::DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      fwpp_pkg::REG_GAIN_P: tune_kp = val;
      fwpp_pkg::REG_GAIN_I: tune_ki = val;
      fwpp_pkg::REG_GAIN_D: tune_kd = val;
      fwpp_pkg::REG_ZONE:   tune_zone = val[fwpp_pkg::ZONE_W-1:0];
      fwpp_pkg::REG_BAND:   tune_band = val[fwpp_pkg::BAND_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    read_register(idx, val);
  endtask

  task automatic set_tuning(input logic [31:0] kp, input logic [31:0] ki,
                            input logic [31:0] kd, input logic [15:0] zone,
                            input logic [7:0] band);
    wait_drained();
    write_register(fwpp_pkg::REG_GAIN_P, kp);
    write_register(fwpp_pkg::REG_GAIN_I, ki);
    write_register(fwpp_pkg::REG_GAIN_D, kd);
    write_register(fwpp_pkg::REG_ZONE, {16'b0, zone});
    write_register(fwpp_pkg::REG_BAND, {24'b0, band});
  endtask

  task automatic test_register_reset_values();
    read_register(fwpp_pkg::REG_GAIN_P, fwpp_pkg::GAIN_P_RST);
    read_register(fwpp_pkg::REG_GAIN_I, fwpp_pkg::GAIN_I_RST);
    read_register(fwpp_pkg::REG_GAIN_D, fwpp_pkg::GAIN_D_RST);
    read_register(fwpp_pkg::REG_ZONE, {16'b0, fwpp_pkg::ZONE_RST});
    read_register(fwpp_pkg::REG_BAND, {24'b0, fwpp_pkg::BAND_RST});
  endtask

  // Extremes of target and position, saturation of the offset and error, and the
  // boundaries of the integral zone and the settle band under reset tuning.
  task automatic test_directed_cases();
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FR, '0, '0, '0);
    send_item(fwpp_pkg::ACT_START, WHEEL_FR, POS_HI, '0, '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FR, '0, POS_LO, fwpp_pkg::vel_t'(600));
    send_item(fwpp_pkg::ACT_START, WHEEL_FR, POS_LO, '0, fwpp_pkg::vel_t'(-600));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FR, '0, POS_HI, fwpp_pkg::vel_t'(-600));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FR, '0, POS_LO, '0);
    send_item(fwpp_pkg::ACT_START, WHEEL_FR, '0, POS_HI, '0);
    send_item(fwpp_pkg::ACT_START, WHEEL_FL, fwpp_pkg::pos_t'(100), '0, '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(0), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(50), fwpp_pkg::vel_t'(17));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(100), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(-150), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(97), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(105), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, fwpp_pkg::pos_t'(106), '0);
    send_item(fwpp_pkg::ACT_START, WHEEL_BR, fwpp_pkg::pos_t'(-200), '0, '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_BR, '0, fwpp_pkg::pos_t'(0), fwpp_pkg::vel_t'(-1));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_BR, '0, fwpp_pkg::pos_t'(1), '0);
    send_item(fwpp_pkg::ACT_START, WHEEL_BL, fwpp_pkg::pos_t'(5), '0, '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_BL, '0, fwpp_pkg::pos_t'(0), fwpp_pkg::vel_t'(600));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_BL, '0, fwpp_pkg::pos_t'(0), fwpp_pkg::vel_t'(-600));
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FR, '0, aim_at(WHEEL_FR, 0), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_FL, '0, aim_at(WHEEL_FL, 0), '0);
    send_item(fwpp_pkg::ACT_TICK,  WHEEL_BR, '0, aim_at(WHEEL_BR, 2), '0);
    wait_drained();
  endtask

  // Holds a large error inside a wide zone so that the integral builds up,
  // clears it with one exact hit and then winds it up the other way.
  task automatic test_integral_windup();
    fwpp_pkg::vel_t v;
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    set_tuning(32'sd0, 32'sd1, 32'sd0, 16'hFFFF, 8'hFF);
    send_item(fwpp_pkg::ACT_START, WHEEL_FR, '0, '0, '0);
    for (int n = 0; n < 2 * WINDUP_TICKS + 1; n++) begin
      v = fwpp_pkg::vel_t'(int'($urandom_range(0, 1200)) - 600);
      if (n < WINDUP_TICKS)
        send_item(fwpp_pkg::ACT_TICK, WHEEL_FR, '0, aim_at(WHEEL_FR, 60000), v);
      else if (n == WINDUP_TICKS)
        send_item(fwpp_pkg::ACT_TICK, WHEEL_FR, '0, aim_at(WHEEL_FR, 0), v);
      else
        send_item(fwpp_pkg::ACT_TICK, WHEEL_FR, '0, aim_at(WHEEL_FR, -60000), v);
    end
    wait_drained();
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Mostly ticks aimed near each wheel's goal, some new moves, some noise.
  task automatic test_random_traffic(input int count);
    logic [1:0] w;
    fwpp_pkg::vel_t v;
    longint miss;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      w = 2'($urandom_range(0, fwpp_pkg::WHEELS - 1));
      v = fwpp_pkg::vel_t'(int'($urandom_range(0, 1200)) - 600);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        if ($urandom_range(0, 2) == 0)
          send_item(fwpp_pkg::ACT_START, w, fwpp_pkg::pos_t'($urandom()), '0, v);
        else
          send_item(fwpp_pkg::ACT_START, w,
                    fwpp_pkg::pos_t'(int'($urandom_range(0, 10000)) - 5000),
                    fwpp_pkg::pos_t'($urandom()), v);
      end else if (pick < 15) begin
        send_item(logic'($urandom_range(0, 1)), w, fwpp_pkg::pos_t'($urandom()),
                  fwpp_pkg::pos_t'($urandom()), v);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          miss = longint'($urandom_range(0, 2 * tune_band + 6)) - (tune_band + 3);
        else if (pick < 80)
          miss = longint'($urandom_range(0, 2 * tune_zone + 100)) - (tune_zone + 50);
        else if (pick < 90)
          miss = 0;
        else
          miss = longint'(fwpp_pkg::pos_t'($urandom()));
        send_item(fwpp_pkg::ACT_TICK, w, fwpp_pkg::pos_t'($urandom()), aim_at(w, miss), v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    fwpp_pkg::fwpp_res_t got;
    fwpp_pkg::fwpp_res_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = out_tdata[$bits(fwpp_pkg::fwpp_res_t)-1:0];
      if (pending_drive_results.size() == 0) begin
        flag_mismatch($sformatf("result %h arrived with nothing outstanding", out_tdata));
      end else begin
        want = pending_drive_results.pop_front();
        results_checked++;
        if (got.drive !== want.drive)
          flag_mismatch($sformatf("drive %0d, expected %0d", got.drive, want.drive));
        if (got.error !== want.error)
          flag_mismatch($sformatf("error %0d, expected %0d", got.error, want.error));
        if (got.settled !== want.settled)
          flag_mismatch($sformatf("settled %b, expected %b", got.settled, want.settled));
        if (got.all_settled !== want.all_settled)
          flag_mismatch($sformatf("all_settled %b, expected %b",
                                  got.all_settled, want.all_settled));
        if (out_tdata[fwpp_pkg::OUT_DATA_W-1:$bits(fwpp_pkg::fwpp_res_t)] !== '0)
          flag_mismatch($sformatf("padding bits set in %h", out_tdata));
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("Timed out with %0d transactions outstanding.", pending_drive_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset_values();
    test_directed_cases();
    test_integral_windup();
    test_random_traffic(450);
    set_tuning(32'sd40000, 32'sd300, -32'sd20000, 16'd150, 8'd3);
    test_random_traffic(450);
    set_tuning(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 8'hFF);
    test_random_traffic(300);
    set_tuning(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 8'h00);
    test_random_traffic(300);
    set_tuning($urandom_range(0, 1 << 18) - (1 << 17), $urandom_range(0, 1 << 12),
               $urandom_range(0, 1 << 17) - (1 << 16), 16'($urandom_range(0, 1000)),
               8'($urandom_range(0, 255)));
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_traffic(250);
    wait_drained();
    $display("Sent %0d transactions (%0d moves, %0d ticks), checked %0d results.",
             items_sent, starts_sent, ticks_sent, results_checked);
    $display("Covered %0d register writes over five tunings including both gain extremes.",
             reg_writes);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total.", mismatch_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
